// ===== hw/rtl/rsq_pkg.sv =====
// Request scheduling queue package: sizes, field offsets and codes.
// Used by request_scheduling_queue. Has no dependencies.
`default_nettype none

package rsq_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 64;
    localparam int OCC_W   = 5;

    // Field placement inside one stored entry (same as the input tdata)
    localparam int CONN_LSB = 0;
    localparam int SIZE_LSB = 16;
    localparam int SIZE_MSB = 47;

    // Command codes (s_tuser)
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes (m_tuser)
    localparam logic [1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [1:0] ST_DEQUEUED   = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/request_scheduling_queue.sv =====
// Request scheduling queue: FIFO or smallest-file-first request queue.
// Only one transaction is in flight: the next request is taken once the result
// has been loaded into the output register, which waits while m_tready holds it.
// A smallest-file-first enqueue and any dequeue walk the stored entries, taking
// each through read and compare/write; a FIFO enqueue writes at the tail directly.
// Reset (aresetn low, synchronous) empties the queue and sets policy to FIFO.
// The entry memory is not cleared; only entries below the count are read.
`default_nettype none

module request_scheduling_queue
    import rsq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: policy (0 FIFO, 1 smallest file first)
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // conn_id[15:0], file_size[47:16], name_tag[63:48]
    input  wire logic [0:0]  s_tuser,   // cmd[0]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // out_conn_id[15:0], out_file_size[47:16],
                                        // out_name_tag[63:48], occupancy[68:64], zero pad
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_WRT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Entry memory
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              policy_reg;
    logic              op_reg, op_next;
    logic              found_reg, found_next;
    entry_t            carry_reg, carry_next;
    entry_t            head_reg, head_next;
    logic [1:0]        status_reg, status_next;

    logic              out_valid_reg, out_valid_next;
    logic [71:0]       out_data_reg, out_data_next;
    logic [1:0]        out_user_reg, out_user_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    entry_t            wr_data;

    logic              s_fire;
    logic [CNT_W-1:0]  k_plus1;
    logic              is_greater;
    logic [OCC_W-1:0]  occ;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign k_plus1  = CNT_W'(k_reg) + CNT_W'(1);
    assign is_greater = rd_data_reg[SIZE_MSB:SIZE_LSB] > carry_reg[SIZE_MSB:SIZE_LSB];
    assign occ = OCC_W'({{OCC_W{1'b0}}, count_next});

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        op_next        = op_reg;
        found_next     = found_reg;
        carry_next     = carry_reg;
        head_next      = head_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_addr        = k_reg;
        rd_addr        = k_reg;
        wr_data        = carry_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next    = s_tuser[0];
                    carry_next = s_tdata;
                    found_next = 1'b0;
                    k_next     = '0;
                    if (s_tuser[0] == CMD_ENQ) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (policy_reg && (count_reg != '0)) begin
                            state_next = S_RD;
                        end else begin
                            state_next = S_WRT;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (op_reg == CMD_ENQ) begin
                    // insert before first strictly larger entry, then ripple
                    if (found_reg || is_greater) begin
                        mem_we     = 1'b1;
                        wr_data    = carry_reg;
                        carry_next = rd_data_reg;
                        found_next = 1'b1;
                    end
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = (k_plus1 == count_reg) ? S_WRT : S_RD;
                end else begin
                    // first read is the head; later reads move down one slot
                    if (k_reg == '0) begin
                        head_next = rd_data_reg;
                    end else begin
                        mem_we  = 1'b1;
                        wr_addr = k_reg - ADDR_W'(1);
                        wr_data = rd_data_reg;
                    end
                    if (k_plus1 == count_reg) begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ST_DEQUEUED;
                        state_next  = S_DONE;
                    end else begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_WRT: begin
                mem_we      = 1'b1;
                wr_addr     = count_reg[ADDR_W-1:0];
                wr_data     = carry_reg;
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_ENQUEUED;
                state_next  = S_DONE;
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    if (status_reg == ST_DEQUEUED) begin
                        out_data_next = {3'd0, occ, head_reg};
                    end else begin
                        out_data_next = {3'd0, occ, {ENTRY_W{1'b0}}};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            policy_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        op_reg       <= op_next;
        found_reg    <= found_next;
        carry_reg    <= carry_next;
        head_reg     <= head_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // Entry memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire
